// File: sv/task_heartbeat_watchdog_unit_macros.svh
// Assertion helpers shared by the checker.
`ifndef TASK_HEARTBEAT_WATCHDOG_UNIT_MACROS_SVH
`define TASK_HEARTBEAT_WATCHDOG_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define THW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define THW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/thw_pkg.sv
package thw_pkg;

    localparam int SLOTS_DEF          = 8;
    localparam int TICK_PERIOD_MS_DEF = 1;
    localparam int SLOTS_MAX          = 32;
    localparam int SLOT_IDX_W         = $clog2(SLOTS_MAX);
    localparam int TICK_W             = 32;
    localparam int MS_PER_SECOND      = 1000;

    typedef enum logic [1:0] {
        FN_REGISTER  = 2'd0,
        FN_HEARTBEAT = 2'd1,
        FN_CHECK     = 2'd2,
        FN_CLEAR     = 2'd3
    } t_func;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_CHECK = 1'b1
    } t_op;

    // Token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic                  active;
        t_op                   op;
        logic [TICK_W-1:0]     val;   // alloc: limit in ticks; check: carried tick
        logic                  done;  // a cell claimed the request
        logic [SLOT_IDX_W-1:0] idx;   // which cell claimed it
    } t_carry;

    // Broadcast writes from the controller to every cell.
    typedef struct packed {
        logic              hb_we;
        logic [2:0]        hb_slot;
        logic [TICK_W-1:0] stamp;
        logic              clr;
    } t_bcast;

endpackage

// File: sv/thw_cell.sv
module thw_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  thw_pkg::t_carry i_carry,
    input  thw_pkg::t_bcast i_bcast,
    output thw_pkg::t_carry o_carry
);
    import thw_pkg::*;

    logic              r_used;
    logic [TICK_W-1:0] r_limit;
    logic [TICK_W-1:0] r_stamp;
    t_carry            r_carry;
    t_carry            n_carry;

    logic [TICK_W:0]   w_diff;
    logic              w_borrow;
    logic              w_raise;
    logic [TICK_W-1:0] w_elapsed;
    logic              w_take;

    // cur - stamp with borrow; a lead of 1 or 2 shows as the top two codes
    assign w_diff   = {1'b0, i_carry.val} - {1'b0, r_stamp};
    assign w_borrow = w_diff[TICK_W];
    assign w_raise  = w_borrow && (&w_diff[TICK_W-1:1]);
    assign w_take   = i_carry.active && !i_carry.done && (i_carry.op == OP_ALLOC) && !r_used;

    always_comb begin
        if (w_raise) begin
            w_elapsed = '0;
        end else if (w_borrow) begin
            w_elapsed = w_diff[TICK_W-1:0] - TICK_W'(1);
        end else begin
            w_elapsed = w_diff[TICK_W-1:0];
        end
    end

    always_comb begin
        n_carry = i_carry;
        if (i_carry.active && !i_carry.done) begin
            if (w_take) begin
                n_carry.done = 1'b1;
                n_carry.idx  = SLOT_IDX_W'(IDX);
            end else if (i_carry.op == OP_CHECK && r_used) begin
                if (w_raise) begin
                    n_carry.val = r_stamp;
                end
                if (w_elapsed > r_limit) begin
                    n_carry.done = 1'b1;
                    n_carry.idx  = SLOT_IDX_W'(IDX);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used        <= 1'b0;
            r_limit       <= '0;
            r_stamp       <= '0;
            r_carry.active <= 1'b0;
        end else begin
            r_carry <= n_carry;
            if (i_bcast.clr) begin
                r_used  <= 1'b0;
                r_limit <= '0;
            end else if (w_take) begin
                r_used  <= 1'b1;
                r_limit <= i_carry.val;
            end
            if (i_bcast.hb_we && (32'(i_bcast.hb_slot) == IDX)) begin
                r_stamp <= i_bcast.stamp;
            end
        end
    end

    assign o_carry = r_carry;

endmodule

// File: sv/task_heartbeat_watchdog_unit.sv
// Path from accept to the result strobe: heartbeat, clear and invalid register go straight
//   to S_RESP; check walks the slot cells; register divides (two-step reciprocal), then walks.
// Throughput: one request at a time; the next accept comes in the cycle after o_done.
//   Rate is set by the cell row, one slot a cycle.
// Reset (i_rst_n low, synchronous): all slots free, limits and stamps zero, unit idle.
// o_done results cannot be stalled by the receiver.
module task_heartbeat_watchdog_unit #(
    parameter int SLOTS          = thw_pkg::SLOTS_DEF,
    parameter int TICK_PERIOD_MS = thw_pkg::TICK_PERIOD_MS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic        i_task_valid,
    input  logic [22:0] i_limit_seconds,
    input  logic [2:0]  i_slot,
    input  logic [31:0] i_tick_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [2:0]  o_slot_assigned,
    output logic        o_overdue,
    output logic [2:0]  o_overdue_slot
);
    import thw_pkg::*;

    // Divide by the tick period as a multiply by a 32-bit reciprocal plus a
    // shift-and-add fixup; exact for every 32-bit dividend.
    localparam int                RecipL   = $clog2(TICK_PERIOD_MS);
    localparam int                RecipSh1 = (RecipL > 0) ? 1 : 0;
    localparam int                RecipSh2 = (RecipL > 0) ? RecipL - 1 : 0;
    localparam logic [63:0]       RecipM64 =
        ((64'd1 << TICK_W) * ((64'd1 << RecipL) - 64'(TICK_PERIOD_MS)))
        / 64'(TICK_PERIOD_MS) + 64'd1;
    localparam logic [TICK_W-1:0] RecipM   = RecipM64[TICK_W-1:0];

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,   // high word of limit_ms * reciprocal
        S_SCALE = 5'b00100,   // fixup and shift, launch the alloc token
        S_CHAIN = 5'b01000,   // token walking the slot cells
        S_RESP  = 5'b10000    // result strobe
    } t_state;

    t_state r_state, n_state;

    // Divider
    logic [TICK_W-1:0]   r_quo, n_quo;       // limit in ms
    logic [TICK_W-1:0]   r_mulhi, n_mulhi;   // high word of the reciprocal product
    logic [2*TICK_W-1:0] w_prod;
    logic [TICK_W-1:0]   w_quot;

    // Cell row links: w_link[0] is the launch register, w_link[SLOTS] the tail.
    t_carry r_launch, n_launch;
    t_bcast r_bcast, n_bcast;
    t_carry w_link [SLOTS+1];

    // Result registers
    logic [1:0] r_status, n_status;
    logic [2:0] r_assigned, n_assigned;
    logic       r_overdue, n_overdue;
    logic [2:0] r_oslot, n_oslot;

    logic w_accept;
    t_carry w_tail;

    assign w_accept = start && !busy;
    assign w_tail   = w_link[SLOTS];
    assign w_link[0] = r_launch;

    // Reciprocal divide: (t1 + ((n - t1) >> sh1)) >> sh2, t1 = high word of n * m
    assign w_prod = (2*TICK_W)'(r_quo) * (2*TICK_W)'(RecipM);
    assign w_quot = (r_mulhi + ((r_quo - r_mulhi) >> RecipSh1)) >> RecipSh2;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        thw_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_carry(w_link[g]),
            .i_bcast(r_bcast),
            .o_carry(w_link[g+1])
        );
    end

    always_comb begin
        n_state         = r_state;
        n_quo           = r_quo;
        n_mulhi         = r_mulhi;
        n_launch        = r_launch;
        n_launch.active = 1'b0;    // launch token lives one cycle
        n_bcast         = r_bcast;
        n_bcast.hb_we   = 1'b0;
        n_bcast.clr     = 1'b0;
        n_status        = r_status;
        n_assigned      = r_assigned;
        n_overdue       = r_overdue;
        n_oslot         = r_oslot;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status   = ST_OK;
                    n_assigned = '0;
                    n_overdue  = 1'b0;
                    n_oslot    = '0;
                    unique case (t_func'(i_func))
                        FN_REGISTER: begin
                            if (!i_task_valid || i_limit_seconds == '0) begin
                                n_status = ST_INVALID;
                                n_state  = S_RESP;
                            end else begin
                                // seconds to ms, wrapping at 32 bits
                                n_quo   = TICK_W'(i_limit_seconds) * TICK_W'(MS_PER_SECOND);
                                n_state = S_DIV;
                            end
                        end
                        FN_HEARTBEAT: begin
                            if (32'(i_slot) < SLOTS) begin
                                n_bcast.hb_we   = 1'b1;
                                n_bcast.hb_slot = i_slot;
                                n_bcast.stamp   = i_tick_value;
                            end else begin
                                n_status = ST_INVALID;
                            end
                            n_state = S_RESP;
                        end
                        FN_CHECK: begin
                            n_launch.active = 1'b1;
                            n_launch.op     = OP_CHECK;
                            n_launch.val    = i_tick_value;
                            n_launch.done   = 1'b0;
                            n_launch.idx    = '0;
                            n_state         = S_CHAIN;
                        end
                        FN_CLEAR: begin
                            n_bcast.clr = 1'b1;
                            n_state     = S_RESP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_mulhi = w_prod[2*TICK_W-1:TICK_W];
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_launch.active = 1'b1;
                n_launch.op     = OP_ALLOC;
                n_launch.val    = w_quot;
                n_launch.done   = 1'b0;
                n_launch.idx    = '0;
                n_state         = S_CHAIN;
            end
            S_CHAIN: begin
                if (w_tail.active) begin
                    if (w_tail.op == OP_ALLOC) begin
                        n_status   = w_tail.done ? ST_OK : ST_FULL;
                        n_assigned = w_tail.done ? 3'(w_tail.idx) : 3'd0;
                    end else begin
                        n_overdue = w_tail.done;
                        n_oslot   = w_tail.done ? 3'(w_tail.idx) : 3'd0;
                    end
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_launch.active <= 1'b0;
            r_bcast.hb_we   <= 1'b0;
            r_bcast.clr     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_bcast  <= n_bcast;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_mulhi    <= n_mulhi;
        r_status   <= n_status;
        r_assigned <= n_assigned;
        r_overdue  <= n_overdue;
        r_oslot    <= n_oslot;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = (r_state == S_RESP);
    assign o_status        = r_status;
    assign o_slot_assigned = r_assigned;
    assign o_overdue       = r_overdue;
    assign o_overdue_slot  = r_oslot;

endmodule

// File: sv/thw_checker.sv
`include "task_heartbeat_watchdog_unit_macros.svh"

module thw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [2:0]  o_slot_assigned,
    input logic        o_overdue,
    input logic [2:0]  o_overdue_slot
);
    import thw_pkg::*;

    `THW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept did not raise busy")
    `THW_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_done, busy, "result shown while idle")
    `THW_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe longer than one cycle")
    `THW_ASSERT_NOW(a_overdue_ok, i_clk, i_rst_n, o_done && o_overdue, o_status == ST_OK && o_slot_assigned == 3'd0, "overdue with register fields set")
    `THW_ASSERT_NOW(a_fail_quiet, i_clk, i_rst_n, o_done && o_status != ST_OK, !o_overdue && o_slot_assigned == 3'd0 && o_overdue_slot == 3'd0, "failed request with nonzero fields")

endmodule

bind task_heartbeat_watchdog_unit thw_checker u_thw_checker (.*);

// File: tb/task_heartbeat_watchdog_unit_tb.sv
module task_heartbeat_watchdog_unit_tb;
    import thw_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int RANDOM_ITEMS = 1425;
    // Longest request is a register; give the tail some margin.
    localparam int DRAIN_CYCLES = SLOTS + 40;

    // One request as the unit sees it.
    typedef struct {
        t_func       func;
        bit          task_valid;
        bit [22:0]   limit_seconds;
        bit [2:0]    slot;
        bit [31:0]   tick;
    } t_wd_request;

    // One result as the unit reports it.
    typedef struct {
        bit [1:0]    status;
        bit [2:0]    slot_assigned;
        bit          overdue;
        bit [2:0]    overdue_slot;
    } t_wd_result;

    // Directed row: the result is typed in only when pinned is set.
    typedef struct {
        t_wd_request req;
        bit          pinned;
        t_wd_result  res;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = FN_CHECK;
    logic        i_task_valid = 1'b0;
    logic [22:0] i_limit_seconds = '0;
    logic [2:0]  i_slot = '0;
    logic [31:0] i_tick_value = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [2:0]  o_slot_assigned;
    logic        o_overdue;
    logic [2:0]  o_overdue_slot;

    // Travels with the request on the input side; the monitor picks it up at accept.
    bit          req_pinned = 1'b0;
    t_wd_result  req_pinned_result = '{default: '0};

    // Watchdog table as the predictor keeps it (reset state: all zero).
    bit          wd_used [SLOTS] = '{default: 1'b0};
    bit [31:0]   wd_limit_ticks [SLOTS] = '{default: '0};
    bit [31:0]   wd_stamp [SLOTS] = '{default: '0};

    t_wd_result  pending_results [$];
    int          errors = 0;
    int          n_register = 0, n_heartbeat = 0, n_check = 0, n_clear = 0;
    int          n_overdue = 0, n_full = 0, n_invalid = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task_heartbeat_watchdog_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_task_valid    (i_task_valid),
        .i_limit_seconds (i_limit_seconds),
        .i_slot          (i_slot),
        .i_tick_value    (i_tick_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_slot_assigned (o_slot_assigned),
        .o_overdue       (o_overdue),
        .o_overdue_slot  (o_overdue_slot)
    );

    // Elapsed ticks with the wrap rule: one short of the modular difference
    // once the counter has wrapped past the stamp.
    function automatic bit [31:0] ticks_since(bit [31:0] cur, bit [31:0] stamp);
        if (cur >= stamp)
            return cur - stamp;
        return (32'hFFFF_FFFF - stamp) + cur;
    endfunction

    // Applies one request to the table copy and returns the result it yields.
    function automatic t_wd_result predict_watchdog(t_wd_request req);
        t_wd_result r;
        bit [31:0]  cur;
        bit [31:0]  prod;
        r = '{default: '0};
        case (req.func)
            FN_REGISTER: begin
                if (!req.task_valid || req.limit_seconds == 0) begin
                    r.status = ST_INVALID;
                end else begin
                    r.status = ST_FULL;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!wd_used[i]) begin
                            // product wraps at 32 bits before the divide
                            prod = 32'(req.limit_seconds) * 32'(MS_PER_SECOND);
                            wd_used[i] = 1'b1;
                            wd_limit_ticks[i] = prod / 32'(TICK_PERIOD_MS_DEF);
                            r.status = ST_OK;
                            r.slot_assigned = 3'(i);
                            break;
                        end
                    end
                end
            end
            FN_HEARTBEAT: begin
                if (req.slot < SLOTS)
                    wd_stamp[req.slot] = req.tick;
                else
                    r.status = ST_INVALID;
            end
            FN_CHECK: begin
                cur = req.tick;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!wd_used[i])
                        continue;
                    // stamp slightly ahead: pull the current tick up, carry it on
                    if (cur < wd_stamp[i] && (wd_stamp[i] - cur) <= 32'd2)
                        cur = wd_stamp[i];
                    if (ticks_since(cur, wd_stamp[i]) > wd_limit_ticks[i]) begin
                        r.overdue = 1'b1;
                        r.overdue_slot = 3'(i);
                        break;
                    end
                end
            end
            default: begin
                // clear frees slots and limits, stamps survive
                for (int i = 0; i < SLOTS; i++) begin
                    wd_used[i] = 1'b0;
                    wd_limit_ticks[i] = '0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic compare_result(t_wd_result want, t_wd_result got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.slot_assigned !== want.slot_assigned) begin
            $error("slot_assigned: expected %0d, got %0d", want.slot_assigned,
                   got.slot_assigned);
            errors++;
        end
        if (got.overdue !== want.overdue) begin
            $error("overdue: expected %0d, got %0d", want.overdue, got.overdue);
            errors++;
        end
        if (got.overdue_slot !== want.overdue_slot) begin
            $error("overdue_slot: expected %0d, got %0d", want.overdue_slot,
                   got.overdue_slot);
            errors++;
        end
    endtask

    // Monitor: results are retired first, then a request accepted at this edge
    // is run through the predictor. Port values read here are the pre-edge ones.
    t_wd_request mon_req;
    t_wd_result  mon_got;
    t_wd_result  mon_pred;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                mon_got = '{status: o_status, slot_assigned: o_slot_assigned,
                            overdue: o_overdue, overdue_slot: o_overdue_slot};
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d", o_status);
                    errors++;
                end else begin
                    compare_result(pending_results.pop_front(), mon_got);
                end
            end
            if (start && busy === 1'b0) begin
                mon_req = '{func: t_func'(i_func), task_valid: i_task_valid,
                            limit_seconds: i_limit_seconds, slot: i_slot,
                            tick: i_tick_value};
                mon_pred = predict_watchdog(mon_req);
                pending_results.push_back(req_pinned ? req_pinned_result : mon_pred);
                case (mon_req.func)
                    FN_REGISTER:  n_register++;
                    FN_HEARTBEAT: n_heartbeat++;
                    FN_CHECK:     n_check++;
                    default:      n_clear++;
                endcase
                n_overdue += mon_pred.overdue;
                if (mon_pred.status == ST_FULL) n_full++;
                if (mon_pred.status == ST_INVALID) n_invalid++;
            end
        end
    end

    // Drives one request, optionally after an idle burst, and returns at the
    // edge where it is accepted. start stays high into the next request.
    task automatic issue_request(t_wd_request req, bit pinned, t_wd_result res,
                                 bit allow_gap);
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_func            <= req.func;
        i_task_valid      <= req.task_valid;
        i_limit_seconds   <= req.limit_seconds;
        i_slot            <= req.slot;
        i_tick_value      <= req.tick;
        req_pinned        <= pinned;
        req_pinned_result <= res;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    function automatic t_script_row script_row(t_func f, bit tv, bit [22:0] lim,
                                               bit [2:0] sl, bit [31:0] tk, bit pin,
                                               bit [1:0] st, bit [2:0] sa,
                                               bit od, bit [2:0] os);
        script_row.req = '{func: f, task_valid: tv, limit_seconds: lim, slot: sl,
                           tick: tk};
        script_row.pinned = pin;
        script_row.res = '{status: st, slot_assigned: sa, overdue: od,
                           overdue_slot: os};
    endfunction

    // Gaps come in stretches: two blocks of 100 requests with gaps, one without,
    // and none over the last 150.
    function automatic bit gaps_allowed(int k);
        return ((k / 100) % 3 != 2) && (k < 25 + RANDOM_ITEMS - 150);
    endfunction

    initial begin
        t_script_row script [$];
        t_wd_request req;
        t_wd_result  none;
        bit [31:0]   now;
        int          k;
        int          pick;

        none = '{default: '0};
        now  = 32'd10_000;

        // Directed part. Fill the table to full, drive carry and wrap cases, clear.
        script.push_back(script_row(FN_CHECK, 1, 0, 0, 32'd0, 1, ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_REGISTER, 0, 5, 0, 0, 1, ST_INVALID, 0, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 0, 0, 0, 1, ST_INVALID, 0, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 1, 0, 0, 1, ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 23'd4294967, 0, 0, 1, ST_OK, 1, 0, 0));
        // 0x7FFFFF seconds wraps in the 32-bit product
        script.push_back(script_row(FN_REGISTER, 1, 23'h7F_FFFF, 0, 0, 1, ST_OK, 2, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 2, 0, 0, 1, ST_OK, 3, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 3, 0, 0, 1, ST_OK, 4, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 4, 0, 0, 1, ST_OK, 5, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 5, 0, 0, 1, ST_OK, 6, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 6, 0, 0, 1, ST_OK, 7, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 9, 0, 0, 1, ST_FULL, 0, 0, 0));
        script.push_back(script_row(FN_HEARTBEAT, 0, 0, 0, 32'd5000, 1, ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_HEARTBEAT, 1, 0, 7, 32'hFFFF_FFFF, 1,
                                    ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_CHECK, 0, 0, 0, 32'd500, 0, ST_OK, 0, 0, 0));
        // stamp two ahead: carried; three ahead: wraps to a huge elapsed time
        script.push_back(script_row(FN_CHECK, 0, 0, 0, 32'd4998, 0, ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_CHECK, 0, 0, 0, 32'd4997, 0, ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_HEARTBEAT, 0, 0, 0, 32'hFFFF_FFFF, 0,
                                    ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_CHECK, 0, 0, 0, 32'd0, 0, ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_CLEAR, 1, 23'h7F_FFFF, 7, 32'hFFFF_FFFF, 1,
                                    ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_CHECK, 0, 0, 0, 32'hFFFF_FFFF, 1, ST_OK, 0, 0, 0));
        // stamp into a free slot is kept
        script.push_back(script_row(FN_HEARTBEAT, 0, 0, 2, 32'd123, 1, ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 1, 0, 0, 1, ST_OK, 0, 0, 0));
        script.push_back(script_row(FN_REGISTER, 1, 1, 0, 0, 1, ST_OK, 1, 0, 0));
        script.push_back(script_row(FN_CHECK, 0, 0, 0, 32'd1123, 0, ST_OK, 0, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        k = 0;
        foreach (script[i]) begin
            issue_request(script[i].req, script[i].pinned, script[i].res,
                          gaps_allowed(k));
            k++;
        end

        // Random part: a moving notion of "now" keeps heartbeats and checks close
        // together, so carries, near misses and overdue slots all show up.
        // Every field is randomized on every request, used or not.
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 49) == 0)
                now = $urandom;
            else
                now = now + 32'($urandom_range(0, 1500));

            req.task_valid    = ($urandom_range(0, 15) != 0);
            req.limit_seconds = 23'($urandom);
            req.slot          = 3'($urandom);
            req.tick          = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                req.func = FN_CLEAR;
            end else if (pick < 28) begin
                req.func = FN_REGISTER;
                case ($urandom_range(0, 19))
                    0, 1:    req.limit_seconds = '0;
                    2, 3:    ;  // full-range seconds
                    4:       req.limit_seconds = 23'(4294966 + $urandom_range(0, 3));
                    default: req.limit_seconds = 23'($urandom_range(1, 6));
                endcase
            end else if (pick < 58) begin
                req.func = FN_HEARTBEAT;
                if ($urandom_range(0, 4) != 0)
                    req.tick = now + 32'($urandom_range(0, 6)) - 32'd3;
            end else begin
                req.func = FN_CHECK;
                if ($urandom_range(0, 9) != 0)
                    req.tick = now + 32'($urandom_range(0, 6)) - 32'd3;
            end

            issue_request(req, 1'b0, none, gaps_allowed(k));
            k++;
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d register (%0d full, %0d invalid), %0d heartbeat,",
                 n_register, n_full, n_invalid, n_heartbeat);
        $display("  %0d check (%0d overdue), %0d clear requests", n_check, n_overdue,
                 n_clear);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog on the bench itself: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
